// ===== hw/rtl/fixed_block_pool_allocator_unit_assert.svh =====
// Assertion macros used by the allocator's checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FAB_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("fab check failed: same-cycle rule");

// Next-cycle implication.
`define FAB_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("fab check failed: next-cycle rule");

`endif

// ===== hw/rtl/fab_pkg.sv =====
`default_nettype none

package fab_pkg;

  // Request kinds (in_tuser)
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes (out_tuser)
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_NOGRANT  = 2'd2;
  localparam logic [1:0] ST_NOTALLOC = 2'd3;

  // Register indexes (byte address / 4)
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [1:0] REG_BLOCKS      = 2'd2;

  localparam logic [31:0] RST_POOL_BASE   = 32'd0;
  localparam logic [15:0] RST_BLOCK_BYTES = 16'd64;
  localparam logic [6:0]  RST_BLOCKS      = 7'd64;

  localparam int IN_W  = 48;
  localparam int OUT_W = 72;

  typedef struct packed {
    logic        req_type;
    logic [15:0] req_size;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] granted_address;
    logic [5:0]  granted_index;
    logic [6:0]  free_count;
    logic [21:0] used_total;
  } res_t;

  typedef struct packed {
    logic clr;    // drop every used bit
    logic shift;  // rotate the ring by one cell
    logic flip;   // toggle the bit leaving the head cell
  } ring_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fab_cell.sv =====
`default_nettype none

module fab_cell
  import fab_pkg::*;
(
  input  wire            clk,
  input  wire            rst_n,
  input  wire ring_ctl_t ctl,
  input  wire            d,
  output logic           q
);

  logic used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
    end else if (ctl.clr) begin
      used_r <= 1'b0;
    end else if (ctl.shift) begin
      used_r <= d;
    end
  end

  assign q = used_r;

endmodule

`default_nettype wire

// ===== hw/rtl/fab_ring.sv =====
`default_nettype none

module fab_ring
  import fab_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  wire            clk,
  input  wire            rst_n,
  input  wire ring_ctl_t ctl,
  output logic           head
);

  logic [MAX_BLOCKS-1:0] q;

  // Cell 0 is the head; bits move toward it and the head bit re-enters at the tail.
  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    logic d;
    if (i == MAX_BLOCKS - 1) begin : g_tail
      assign d = q[0] ^ ctl.flip;
    end else begin : g_mid
      assign d = q[i+1];
    end
    fab_cell u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (ctl),
      .d    (d),
      .q    (q[i])
    );
  end

  assign head = q[0];

endmodule

`default_nettype wire

// ===== hw/rtl/fab_ctrl.sv =====
`default_nettype none

module fab_ctrl
  import fab_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  req_t  req,
  input  wire  [31:0] pool_base,
  input  wire  [15:0] block_bytes,
  input  wire  [6:0]  blocks_in_use,
  input  wire         pool_clr,
  input  wire         head,
  output ring_ctl_t   ring_ctl,
  output logic        out_valid,
  input  wire         out_ready,
  output res_t        res
);

  localparam int CW       = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int KW       = (CW > 7) ? CW : 7;
  localparam int LIM      = (MAX_BLOCKS < 127) ? MAX_BLOCKS : 127;
  localparam int RST_FREE = (MAX_BLOCKS < 64) ? MAX_BLOCKS : 64;
  localparam logic [CW-1:0] LAST = CW'(MAX_BLOCKS - 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t      state_r;
  req_t        req_r;
  logic        armed_r;
  logic        zero_r;
  logic        found_r;
  logic [CW-1:0] idx_r;
  logic [31:0] cur_addr_r;
  logic [31:0] gaddr_r;
  logic [5:0]  gidx_r;
  logic [6:0]  free_cnt_r;
  logic [22:0] used_bytes_r;
  logic        out_valid_r;
  res_t        res_r;

  logic [6:0]  n_eff;
  logic        in_pool;
  logic        is_alloc;
  logic        head_ok;
  logic        hit;
  logic        accept;
  logic [1:0]  status_nxt;

  always_comb begin
    n_eff    = (blocks_in_use > 7'(LIM)) ? 7'(LIM) : blocks_in_use;
    in_pool  = KW'(idx_r) < KW'(n_eff);
    is_alloc = (req_r.req_type == REQ_ALLOC);
    head_ok  = is_alloc ? !head : (head && (cur_addr_r == req_r.release_address));
    hit      = (state_r == S_SCAN) && armed_r && !found_r && in_pool && head_ok;
    in_ready = (state_r == S_IDLE) && !pool_clr;
    accept   = in_valid && in_ready;
    ring_ctl.clr   = pool_clr;
    ring_ctl.shift = (state_r == S_SCAN);
    ring_ctl.flip  = hit;
    if (zero_r) begin
      status_nxt = ST_ZERO;
    end else if (found_r) begin
      status_nxt = ST_OK;
    end else if (is_alloc) begin
      status_nxt = ST_NOGRANT;
    end else begin
      status_nxt = ST_NOTALLOC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      free_cnt_r   <= 7'(RST_FREE);
      used_bytes_r <= '0;
      found_r      <= 1'b0;
      armed_r      <= 1'b0;
      zero_r       <= 1'b0;
      idx_r        <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (pool_clr) begin
        free_cnt_r   <= n_eff;
        used_bytes_r <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            req_r      <= req;
            found_r    <= 1'b0;
            idx_r      <= '0;
            cur_addr_r <= pool_base;
            gaddr_r    <= '0;
            gidx_r     <= '0;
            if (req.req_type == REQ_ALLOC) begin
              zero_r  <= (req.req_size == '0);
              armed_r <= (req.req_size != '0) && (req.req_size <= block_bytes);
            end else begin
              zero_r  <= (req.release_address == '0);
              armed_r <= (req.release_address != '0);
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            found_r <= 1'b1;
            gidx_r  <= 6'(idx_r);
            if (is_alloc) begin
              gaddr_r      <= cur_addr_r;
              free_cnt_r   <= free_cnt_r - 7'd1;
              used_bytes_r <= used_bytes_r + 23'(block_bytes);
            end else begin
              free_cnt_r   <= free_cnt_r + 7'd1;
              used_bytes_r <= used_bytes_r - 23'(block_bytes);
            end
          end
          cur_addr_r <= cur_addr_r + 32'(block_bytes);
          if (idx_r == LAST) begin
            state_r <= S_DONE;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: begin
          // hold here while the previous result is still unread
          if (!out_valid_r || out_ready) begin
            out_valid_r           <= 1'b1;
            res_r.status          <= status_nxt;
            res_r.granted_address <= gaddr_r;
            res_r.granted_index   <= gidx_r;
            res_r.free_count      <= free_cnt_r;
            res_r.used_total      <= used_bytes_r[21:0];
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_block_pool_allocator_unit.sv =====
// Fixed block pool allocator.
// Input stream: one request per item; in_tuser is the kind (0 allocate, 1 free),
// in_tdata carries the size and the address to release.
// Output stream: one result per request; out_tuser is the status, out_tdata
// the granted address, block index, free block count and used byte count.
// Configuration: APB registers pool_base (0x0), block_bytes (0x4) and
// blocks_in_use (0x8); any write empties the pool. Write only while idle.
// The used bits sit in a ring of MAX_BLOCKS cells that rotates by one cell per
// clock while a request is scanned, under a single address compare at the head,
// so a request needs one full turn; a new request is not taken until the result
// of the previous one has been written to the output register.
// The cycle after a configuration write no request is taken.
// Reset: every block free, registers at base 0, 64-byte blocks, 64 blocks.
// Stall: a finished result waits in the output register; the next request is
// still accepted and scanned, then held until the receiver takes the first.
`default_nettype none

module fixed_block_pool_allocator_unit
  import fab_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire  [IN_W-1:0]   in_tdata,   // req_size[15:0], release_address[47:16]
  input  wire               in_tuser,   // req_type[0]
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // granted_address[31:0], granted_index[37:32],
                                        // free_count[44:38], used_total[66:45], zero pad
  output logic [1:0]        out_tuser,  // status[1:0]
  input  wire               cfg_psel,
  input  wire               cfg_penable,
  input  wire               cfg_pwrite,
  input  wire  [3:0]        cfg_paddr,
  input  wire  [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [31:0] pool_base_r;
  logic [15:0] block_bytes_r;
  logic [6:0]  blocks_r;
  logic        pool_clr_r;

  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        head;
  ring_ctl_t   ring_ctl;
  req_t        req;
  res_t        res;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= RST_POOL_BASE;
      block_bytes_r <= RST_BLOCK_BYTES;
      blocks_r      <= RST_BLOCKS;
      pool_clr_r    <= 1'b0;
    end else begin
      pool_clr_r <= 1'b0;
      if (cfg_wr) begin
        unique case (reg_idx)
          REG_POOL_BASE: begin
            pool_base_r <= cfg_pwdata;
            pool_clr_r  <= 1'b1;
          end
          REG_BLOCK_BYTES: begin
            block_bytes_r <= cfg_pwdata[15:0];
            pool_clr_r    <= 1'b1;
          end
          REG_BLOCKS: begin
            blocks_r   <= cfg_pwdata[6:0];
            pool_clr_r <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_POOL_BASE:   cfg_prdata = pool_base_r;
      REG_BLOCK_BYTES: cfg_prdata = {16'd0, block_bytes_r};
      REG_BLOCKS:      cfg_prdata = {25'd0, blocks_r};
      default:         cfg_prdata = '0;
    endcase
  end

  assign req.req_type        = in_tuser;
  assign req.req_size        = in_tdata[15:0];
  assign req.release_address = in_tdata[47:16];

  fab_ring #(.MAX_BLOCKS(MAX_BLOCKS)) u_ring (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ring_ctl),
    .head (head)
  );

  fab_ctrl #(.MAX_BLOCKS(MAX_BLOCKS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req          (req),
    .pool_base    (pool_base_r),
    .block_bytes  (block_bytes_r),
    .blocks_in_use(blocks_r),
    .pool_clr     (pool_clr_r),
    .head         (head),
    .ring_ctl     (ring_ctl),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .res          (res)
  );

  assign out_tuser = res.status;
  assign out_tdata = {5'd0, res.used_total, res.free_count, res.granted_index,
                      res.granted_address};

endmodule

`default_nettype wire

// ===== hw/rtl/fab_chk.sv =====
`default_nettype none
`include "fixed_block_pool_allocator_unit_assert.svh"

module fab_chk
  import fab_pkg::*;
#(
  parameter int MAX_BLOCKS = 64
) (
  input wire             clk,
  input wire             rst_n,
  input wire             in_tvalid,
  input wire             in_tready,
  input wire             out_tvalid,
  input wire             out_tready,
  input wire [OUT_W-1:0] out_tdata,
  input wire [1:0]       out_tuser
);

  localparam int LIM = (MAX_BLOCKS < 127) ? MAX_BLOCKS : 127;
  localparam logic [6:0] FREE_MAX = 7'(LIM);

  // A result under stall stays offered.
  `FAB_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)

  // One request at a time: the input closes right after an accept.
  `FAB_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready)

  // Any failed request reports neither an address nor an index.
  `FAB_ASSERT_IMP(a_fail_zero, clk, rst_n, out_tvalid && (out_tuser != ST_OK), out_tdata[37:0] == '0)

  // Free count never exceeds the pool size.
  `FAB_ASSERT_IMP(a_free_bound, clk, rst_n, out_tvalid, out_tdata[44:38] <= FREE_MAX)

endmodule

bind fixed_block_pool_allocator_unit fab_chk #(.MAX_BLOCKS(MAX_BLOCKS)) u_fab_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import fab_pkg::*;

  localparam int POOL_MAX = 64;

  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] reg_val;
    req_t        req;
    bit          typed;
    res_t        want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic [1:0]        out_tuser;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [3:0]        cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // shadow of the pool, advanced once per accepted request
  logic [31:0] base_addr;
  logic [15:0] blk_size;
  logic [6:0]  blk_count;
  bit          occupied [POOL_MAX];
  logic [6:0]  free_left;
  logic [22:0] bytes_held;

  res_t pending [$];
  int   errors;
  bit   calm;
  int   ready_left;
  int   ready_roll;
  res_t want_r;
  row_t script [25];

  fixed_block_pool_allocator_unit #(.MAX_BLOCKS(POOL_MAX)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] blk_addr(int idx);
    return base_addr + 32'(idx) * 32'(blk_size);
  endfunction

  // first-fit grant / exact-base release, same order of search as the block
  function automatic res_t pool_serve(req_t r);
    res_t o;
    int   n;
    n = (blk_count > POOL_MAX) ? POOL_MAX : int'(blk_count);
    o = '0;
    o.status = ST_NOGRANT;
    if (r.req_type == REQ_ALLOC) begin
      if (r.req_size == 16'd0) begin
        o.status = ST_ZERO;
      end else if (r.req_size <= blk_size) begin
        for (int i = 0; i < n; i++) begin
          if (!occupied[i]) begin
            occupied[i] = 1'b1;
            bytes_held = bytes_held + 23'(blk_size);
            free_left = free_left - 7'd1;
            o.status = ST_OK;
            o.granted_address = blk_addr(i);
            o.granted_index = 6'(i);
            break;
          end
        end
      end
    end else begin
      if (r.release_address == 32'd0) begin
        o.status = ST_ZERO;
      end else begin
        o.status = ST_NOTALLOC;
        for (int i = 0; i < n; i++) begin
          if (occupied[i] && blk_addr(i) == r.release_address) begin
            occupied[i] = 1'b0;
            bytes_held = bytes_held - 23'(blk_size);
            free_left = free_left + 7'd1;
            o.status = ST_OK;
            o.granted_index = 6'(i);
            break;
          end
        end
      end
    end
    o.free_count = free_left;
    o.used_total = bytes_held[21:0];
    return o;
  endfunction

  function automatic row_t req_row(logic kind, logic [15:0] size, logic [31:0] addr,
                                   bit typed, logic [1:0] st, logic [31:0] ga,
                                   logic [5:0] gi, logic [6:0] fc, logic [21:0] ut);
    row_t w;
    w = '{kind: ROW_REQ, default: '0};
    w.req.req_type = kind;
    w.req.req_size = size;
    w.req.release_address = addr;
    w.typed = typed;
    w.want.status = st;
    w.want.granted_address = ga;
    w.want.granted_index = gi;
    w.want.free_count = fc;
    w.want.used_total = ut;
    return w;
  endfunction

  function automatic row_t cfg_row(logic [1:0] idx, logic [31:0] val);
    row_t w;
    w = '{kind: ROW_CFG, default: '0};
    w.reg_idx = idx;
    w.reg_val = val;
    return w;
  endfunction

  task automatic push_req(input req_t r, input bit typed, input res_t want);
    res_t predicted;
    in_tdata <= {r.release_address, r.req_size};
    in_tuser <= r.req_type;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predicted = pool_serve(r);
    pending.push_back(typed ? want : predicted);
  endtask

  // hold the sender until every request has been answered
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_POOL_BASE:   base_addr = val;
      REG_BLOCK_BYTES: blk_size = val[15:0];
      default:         blk_count = val[6:0];
    endcase
    // any write empties the pool
    occupied = '{default: 1'b0};
    free_left = (blk_count > POOL_MAX) ? 7'(POOL_MAX) : blk_count;
    bytes_held = '0;
  endtask

  // receiver: random ready/stall runs, steady ready while calm
  always @(posedge clk) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else if (calm) begin
      out_tready <= 1'b1;
      ready_left <= 16;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        out_tready <= 1'b1;
        ready_left <= $urandom_range(0, 12);
      end else if (ready_roll < 93) begin
        out_tready <= 1'b0;
        ready_left <= $urandom_range(0, 5);
      end else begin
        out_tready <= 1'b0;
        ready_left <= $urandom_range(20, 150);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        want_r = pending.pop_front();
        if (out_tuser !== want_r.status) begin
          $error("status: expected %0d, actual %0d", want_r.status, out_tuser);
          errors++;
        end
        if (out_tdata[31:0] !== want_r.granted_address) begin
          $error("granted_address: expected %h, actual %h",
                 want_r.granted_address, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[37:32] !== want_r.granted_index) begin
          $error("granted_index: expected %0d, actual %0d",
                 want_r.granted_index, out_tdata[37:32]);
          errors++;
        end
        if (out_tdata[44:38] !== want_r.free_count) begin
          $error("free_count: expected %0d, actual %0d",
                 want_r.free_count, out_tdata[44:38]);
          errors++;
        end
        if (out_tdata[66:45] !== want_r.used_total) begin
          $error("used_total: expected %0d, actual %0d",
                 want_r.used_total, out_tdata[66:45]);
          errors++;
        end
      end
    end
  end

  initial begin
    #100_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    req_t        r;
    res_t        none;
    int          ph;
    int          n_items;
    int          roll;
    int          gap;
    int          fill_bias;
    int          idx;
    int          live [$];
    logic [31:0] new_base;
    logic [15:0] new_size;
    logic [6:0]  new_count;

    errors = 0;
    none = '0;
    calm = 1'b0;
    ready_left = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= REQ_ALLOC;
    out_tready <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    base_addr = RST_POOL_BASE;
    blk_size = RST_BLOCK_BYTES;
    blk_count = RST_BLOCKS;
    occupied = '{default: 1'b0};
    free_left = RST_BLOCKS;
    bytes_held = '0;

    // after reset: base 0, 64-byte blocks, 64 blocks
    script[0]  = req_row(REQ_ALLOC, 16'd0, 32'd0, 1, ST_ZERO, 0, 0, 64, 0);
    script[1]  = req_row(REQ_ALLOC, 16'd65, 32'd0, 1, ST_NOGRANT, 0, 0, 64, 0);
    script[2]  = req_row(REQ_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 1, ST_NOGRANT, 0, 0, 64, 0);
    script[3]  = req_row(REQ_ALLOC, 16'd1, 32'd0, 1, ST_OK, 0, 0, 63, 64);
    script[4]  = req_row(REQ_ALLOC, 16'd64, 32'd0, 1, ST_OK, 64, 1, 62, 128);
    script[5]  = req_row(REQ_FREE, 16'hFFFF, 32'd0, 1, ST_ZERO, 0, 0, 62, 128);
    script[6]  = req_row(REQ_FREE, 16'd0, 32'd64, 1, ST_OK, 0, 1, 63, 64);
    script[7]  = req_row(REQ_FREE, 16'd0, 32'd64, 1, ST_NOTALLOC, 0, 0, 63, 64);
    script[8]  = req_row(REQ_FREE, 16'd0, 32'hFFFF_FFFF, 1, ST_NOTALLOC, 0, 0, 63, 64);
    script[9]  = req_row(REQ_FREE, 16'd0, 32'd32, 1, ST_NOTALLOC, 0, 0, 63, 64);
    script[10] = req_row(REQ_ALLOC, 16'd7, 32'd0, 1, ST_OK, 64, 1, 62, 128);
    // empty pool
    script[11] = cfg_row(REG_BLOCKS, 32'd0);
    script[12] = req_row(REQ_ALLOC, 16'd1, 32'd0, 1, ST_NOGRANT, 0, 0, 0, 0);
    script[13] = req_row(REQ_FREE, 16'd0, 32'h40, 1, ST_NOTALLOC, 0, 0, 0, 0);
    // count above the pool size, then zero-byte blocks
    script[14] = cfg_row(REG_BLOCKS, 32'd127);
    script[15] = cfg_row(REG_BLOCK_BYTES, 32'd0);
    script[16] = req_row(REQ_ALLOC, 16'd1, 32'd0, 1, ST_NOGRANT, 0, 0, 64, 0);
    script[17] = req_row(REQ_ALLOC, 16'd0, 32'd0, 1, ST_ZERO, 0, 0, 64, 0);
    // largest blocks, base chosen so that block 1 wraps to address zero
    script[18] = cfg_row(REG_BLOCK_BYTES, 32'hFFFF);
    script[19] = cfg_row(REG_POOL_BASE, 32'hFFFF_0001);
    script[20] = req_row(REQ_ALLOC, 16'hFFFF, 32'd0, 1, ST_OK, 32'hFFFF_0001, 0, 63, 65535);
    script[21] = req_row(REQ_ALLOC, 16'd1, 32'd0, 1, ST_OK, 0, 1, 62, 131070);
    script[22] = req_row(REQ_FREE, 16'd0, 32'd0, 1, ST_ZERO, 0, 0, 62, 131070);
    script[23] = req_row(REQ_FREE, 16'd0, 32'hFFFF_0001, 1, ST_OK, 0, 0, 63, 65535);
    script[24] = req_row(REQ_ALLOC, 16'h8001, 32'h1234_5678, 0, 0, 0, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        push_req(script[i].req, script[i].typed, script[i].want);
      end
    end

    for (ph = 0; ph < 16; ph++) begin
      settle();
      case (ph % 4)
        0:       new_base = 32'd0;
        1:       new_base = 32'hFFFF_FFFF;
        default: new_base = $urandom;
      endcase
      if (ph == 3) new_size = 16'd1;
      else if (ph == 5 || ph == 11) new_size = 16'hFFFF;
      else if (ph == 7) new_size = 16'd0;
      else if (ph % 2 == 0) new_size = 16'($urandom_range(1, 64));
      else new_size = 16'($urandom_range(1, 65535));
      if (ph == 2) new_count = 7'd1;
      else if (ph == 4) new_count = 7'd0;
      else if (ph == 6) new_count = 7'd127;
      else if (ph == 9) new_count = 7'd64;
      else if (ph == 10) new_count = 7'd65;
      else if (ph % 3 == 0) new_count = 7'($urandom_range(1, 8));
      else new_count = 7'($urandom_range(1, 64));
      write_reg(REG_POOL_BASE, new_base);
      write_reg(REG_BLOCK_BYTES, {16'd0, new_size});
      write_reg(REG_BLOCKS, {25'd0, new_count});
      calm = (ph % 5 == 2);
      n_items = (new_count == 0 || new_size == 0) ? 30 : 115;
      fill_bias = 60;

      for (int k = 0; k < n_items; k++) begin
        if (k % 32 == 0) fill_bias = $urandom_range(25, 80);
        r.req_type = 1'($urandom);
        r.req_size = 16'($urandom);
        r.release_address = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          // noise: random kind and fields, sometimes zeroed
          if (roll < 3) begin
            r.req_size = '0;
            r.release_address = '0;
          end
        end else if (roll < 15) begin
          r.req_type = REQ_ALLOC;
          if (blk_size != 16'hFFFF) r.req_size = 16'($urandom_range(int'(blk_size) + 1, 65535));
        end else if (roll < 22) begin
          // release of a random block, free or in use, or a misaligned address
          r.req_type = REQ_FREE;
          idx = $urandom_range(0, POOL_MAX - 1);
          r.release_address = blk_addr(idx) + 32'($urandom_range(0, 1));
        end else if ($urandom_range(0, 99) < fill_bias) begin
          r.req_type = REQ_ALLOC;
          r.req_size = (blk_size == 0) ? 16'($urandom_range(1, 65535))
                                       : 16'($urandom_range(1, int'(blk_size)));
        end else begin
          r.req_type = REQ_FREE;
          live.delete();
          foreach (occupied[j]) if (occupied[j]) live.push_back(j);
          if (live.size() != 0)
            r.release_address = blk_addr(live[$urandom_range(0, live.size() - 1)]);
        end

        gap = 0;
        if (!calm) begin
          roll = $urandom_range(0, 99);
          if (roll < 70) gap = 0;
          else if (roll < 96) gap = $urandom_range(1, 8);
          else gap = $urandom_range(30, 300);
        end
        if ($urandom_range(0, 149) == 0) begin
          settle();
        end else if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        push_req(r, 1'b0, none);
      end
    end

    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (2 * POOL_MAX + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
